// ===== sv/b3c_pkg.sv =====
// shared types, constants and mixing function for the chained block compressor
package b3c_pkg;

  localparam int NUM_ROUNDS      = 7;
  localparam int STEPS_PER_ROUND = 4;
  localparam int NUM_STEPS       = NUM_ROUNDS * STEPS_PER_ROUND;
  localparam int WORDS_PER_BLOCK = 16;
  localparam int CV_WORDS        = 8;
  localparam int NUM_LANES       = 4;

  typedef logic [31:0] word_t;

  localparam word_t BLOCK_BYTES = 32'd64;

  localparam word_t IV [4] = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A};

  localparam logic [3:0] MSG_PERM [16] = '{
    4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
    4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8
  };

  // state word positions of the b, c and d inputs of each lane
  localparam logic [3:0] COL_B [4]  = '{4'd4, 4'd5, 4'd6, 4'd7};
  localparam logic [3:0] COL_C [4]  = '{4'd8, 4'd9, 4'd10, 4'd11};
  localparam logic [3:0] COL_D [4]  = '{4'd12, 4'd13, 4'd14, 4'd15};
  localparam logic [3:0] DIAG_B [4] = '{4'd5, 4'd6, 4'd7, 4'd4};
  localparam logic [3:0] DIAG_C [4] = '{4'd10, 4'd11, 4'd8, 4'd9};
  localparam logic [3:0] DIAG_D [4] = '{4'd15, 4'd12, 4'd13, 4'd14};

  typedef enum logic [2:0] {
    REG_KEY_01      = 3'd0,
    REG_KEY_23      = 3'd1,
    REG_KEY_45      = 3'd2,
    REG_KEY_67      = 3'd3,
    REG_COUNTER     = 3'd4,
    REG_BASE_FLAGS  = 3'd5,
    REG_START_FLAGS = 3'd6,
    REG_END_FLAGS   = 3'd7
  } reg_index_t;

  typedef struct packed {
    word_t [15:0] words;
    logic         first;
    logic         last;
  } job_t;

  typedef struct packed {
    word_t [7:0] key;
    logic [63:0] counter;
    logic [7:0]  base_flags;
    logic [7:0]  start_flags;
    logic [7:0]  end_flags;
  } cfg_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quad_t;

  function automatic word_t ror(word_t w, int unsigned n);
    return (w >> n) | (w << (32 - n));
  endfunction

  // one half of the g mix: rotations 16/12 on the first half, 8/7 on the second
  function automatic quad_t half_mix(word_t a, word_t b, word_t c, word_t d, word_t mw,
                                     logic second);
    word_t a1;
    word_t b1;
    word_t c1;
    word_t d1;
    a1 = a + b + mw;
    d1 = second ? ror(d ^ a1, 8) : ror(d ^ a1, 16);
    c1 = c + d1;
    b1 = second ? ror(b ^ c1, 7) : ror(b ^ c1, 12);
    return quad_t'{a: a1, b: b1, c: c1, d: d1};
  endfunction

endpackage

// ===== sv/blake3_chained_block_compress.sv =====
// top level: configuration registers, word front end, block queue and compression core
//
// Message words are taken one per cycle (start high, busy low); busy rises only on the
// sixteenth word of a block while the block queue is full. Each queued block runs
// through the compression core as a load step, 28 half-mix steps (7 rounds of column
// and diagonal halves over four lanes) and a feed-forward step; the core takes the
// next block only once it is back in idle. On a last block the core then sends the
// eight chaining words, one per cycle with done high for that cycle only; every output
// transfer is taken, there is no way to hold it off. Configuration writes take effect
// at once and belong between messages.
module blake3_chained_block_compress #(
  parameter int QueueDepth = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  b3c_pkg::word_t msg_word,
  input  logic           last_block,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [63:0]    cfg_data,
  output logic           done,
  output b3c_pkg::word_t digest_word,
  output logic [2:0]     word_index,
  output logic           last_out
);
  import b3c_pkg::*;

  cfg_t cfg;
  job_t push_job;
  job_t head_job;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_KEY_01: begin
          cfg.key[0] <= cfg_data[31:0];
          cfg.key[1] <= cfg_data[63:32];
        end
        REG_KEY_23: begin
          cfg.key[2] <= cfg_data[31:0];
          cfg.key[3] <= cfg_data[63:32];
        end
        REG_KEY_45: begin
          cfg.key[4] <= cfg_data[31:0];
          cfg.key[5] <= cfg_data[63:32];
        end
        REG_KEY_67: begin
          cfg.key[6] <= cfg_data[31:0];
          cfg.key[7] <= cfg_data[63:32];
        end
        REG_COUNTER:     cfg.counter     <= cfg_data;
        REG_BASE_FLAGS:  cfg.base_flags  <= cfg_data[7:0];
        REG_START_FLAGS: cfg.start_flags <= cfg_data[7:0];
        REG_END_FLAGS:   cfg.end_flags   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  b3c_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .msg_word   (msg_word),
    .last_block (last_block),
    .q_full     (q_full),
    .busy       (busy),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  b3c_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  b3c_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .job         (head_job),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .done        (done),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_out    (last_out)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full)) else $error("block pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty)) else $error("block popped from empty queue");

  a_digest_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> word_index == 3'd0) else $error("digest does not start at word 0");

  a_digest_runs_on: assert property (@(posedge clk) disable iff (rst)
    done && !last_out |=> done && word_index == 3'($past(word_index) + 3'd1))
    else $error("digest words not contiguous");
`endif

endmodule

// ===== sv/b3c_front.sv =====
// word collection and block classification in front of the block queue
module b3c_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  b3c_pkg::word_t msg_word,
  input  logic           last_block,
  input  logic           q_full,
  output logic           busy,
  output logic           q_push,
  output b3c_pkg::job_t  q_job
);
  import b3c_pkg::*;

  word_t      blk [WORDS_PER_BLOCK-1];
  logic [3:0] word_count;
  logic       first_pending;
  logic       accept;
  logic       block_end;

  assign block_end = (word_count == 4'(WORDS_PER_BLOCK - 1));
  // only the closing word of a block needs room in the queue
  assign busy      = block_end && q_full;
  assign accept    = start && !busy;
  assign q_push    = accept && block_end;

  always_comb begin
    for (int i = 0; i < WORDS_PER_BLOCK - 1; i++) begin
      q_job.words[i] = blk[i];
    end
    q_job.words[WORDS_PER_BLOCK-1] = msg_word;
    q_job.first = first_pending;
    q_job.last  = last_block;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count    <= '0;
      first_pending <= 1'b1;
    end else if (accept) begin
      if (block_end) begin
        word_count    <= '0;
        first_pending <= last_block;
      end else begin
        word_count <= word_count + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !block_end) begin
      blk[word_count] <= msg_word;
    end
  end

endmodule

// ===== sv/b3c_queue.sv =====
// short queue of complete blocks between collection and compression
module b3c_queue #(
  parameter int Depth = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  b3c_pkg::job_t push_job,
  input  logic          pop,
  output b3c_pkg::job_t head,
  output logic          full,
  output logic          empty
);
  import b3c_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  job_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntW'(Depth));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      priority if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== sv/b3c_core.sv =====
// compression engine: four lanes, one half g mix per cycle, then output words on a last block
module b3c_core (
  input  logic           clk,
  input  logic           rst,
  input  b3c_pkg::cfg_t  cfg,
  input  b3c_pkg::job_t  job,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           done,
  output b3c_pkg::word_t digest_word,
  output logic [2:0]     word_index,
  output logic           last_out
);
  import b3c_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_FEED = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t     state;
  logic [4:0] step;
  logic [2:0] idx;
  logic       last_job;
  word_t      v [WORDS_PER_BLOCK];
  word_t      m [WORDS_PER_BLOCK];
  word_t      cv [CV_WORDS];

  word_t      v_mix [WORDS_PER_BLOCK];
  word_t      m_perm [WORDS_PER_BLOCK];
  quad_t      lane_res [NUM_LANES];
  logic [3:0] lb [NUM_LANES];
  logic [3:0] lc [NUM_LANES];
  logic [3:0] ld [NUM_LANES];
  logic       diag;
  logic       second;
  logic [7:0] flags;

  assign second = step[0];
  assign diag   = step[1];
  assign q_pop  = (state == ST_IDLE) && !q_empty;

  assign flags = cfg.base_flags | (job.first ? cfg.start_flags : 8'h00)
               | (job.last ? cfg.end_flags : 8'h00);

  always_comb begin
    for (int j = 0; j < NUM_LANES; j++) begin
      lb[j] = diag ? DIAG_B[j] : COL_B[j];
      lc[j] = diag ? DIAG_C[j] : COL_C[j];
      ld[j] = diag ? DIAG_D[j] : COL_D[j];
      // message word 8*diag + 2*lane + second
      lane_res[j] = half_mix(v[j], v[lb[j]], v[lc[j]], v[ld[j]],
                             m[{diag, 2'(j), second}], second);
    end
    v_mix = v;
    for (int j = 0; j < NUM_LANES; j++) begin
      v_mix[j]     = lane_res[j].a;
      v_mix[lb[j]] = lane_res[j].b;
      v_mix[lc[j]] = lane_res[j].c;
      v_mix[ld[j]] = lane_res[j].d;
    end
    for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
      m_perm[i] = m[MSG_PERM[i]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      idx   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          step <= step + 5'd1;
          if (step == 5'(NUM_STEPS - 1)) begin
            state <= ST_FEED;
          end
        end
        ST_FEED: begin
          idx   <= '0;
          state <= last_job ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          done <= 1'b1;
          idx  <= idx + 3'd1;
          if (idx == 3'(CV_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          for (int i = 0; i < CV_WORDS; i++) begin
            v[i] <= job.first ? cfg.key[i] : cv[i];
          end
          for (int i = 0; i < 4; i++) begin
            v[CV_WORDS+i] <= IV[i];
          end
          v[12] <= cfg.counter[31:0];
          v[13] <= cfg.counter[63:32];
          v[14] <= BLOCK_BYTES;
          v[15] <= {24'h000000, flags};
          for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
            m[i] <= job.words[i];
          end
          last_job <= job.last;
        end
      end
      ST_RUN: begin
        v <= v_mix;
        // schedule moves on after the diagonal second half closes a round
        if (step[1:0] == 2'b11) begin
          m <= m_perm;
        end
      end
      ST_FEED: begin
        for (int i = 0; i < CV_WORDS; i++) begin
          cv[i] <= v[i] ^ v[i+CV_WORDS];
        end
      end
      ST_EMIT: begin
        digest_word <= cv[idx];
        word_index  <= idx;
        last_out    <= (idx == 3'(CV_WORDS - 1));
      end
      default: ;
    endcase
  end

endmodule

// ===== tb/tb_blake3_chained_block_compress.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the chained block compressor: directed blocks, then random messages
module tb_blake3_chained_block_compress;
  import b3c_pkg::*;

  localparam int SETTLE_CYCLES   = 120;
  localparam int STALL_LIMIT     = 3000;
  localparam int WORDS_PER_PHASE = 90;

  localparam word_t CHAIN_IV [4] = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A};
  localparam int SCHEDULE [16] = '{2, 6, 3, 10, 7, 0, 4, 13, 1, 11, 12, 5, 9, 14, 15, 8};

  typedef enum logic [2:0] {
    FILL_ZERO, FILL_ONES, FILL_HALVES, FILL_CHECKER, FILL_COUNT, FILL_RANDOM
  } fill_t;

  // how last_block behaves on the fifteen words that do not end a block
  typedef enum logic [1:0] {MARK_AGREE, MARK_OPPOSE, MARK_RANDOM} mark_t;

  typedef enum logic [2:0] {SET_KEEP, SET_ZERO, SET_ONES, SET_RANDOM, SET_MIXED} setting_t;

  typedef struct packed {
    setting_t settings;
    fill_t    fill;
    logic     last;
    mark_t    marks;
  } block_row_t;

  typedef struct packed {
    word_t      word;
    logic [2:0] index;
    logic       last;
  } digest_beat_t;

  localparam block_row_t DIRECTED [5] = '{
    '{SET_KEEP,  FILL_ZERO,    1'b1, MARK_AGREE},   // reset settings, single-block message
    '{SET_ONES,  FILL_ONES,    1'b1, MARK_OPPOSE},
    '{SET_ZERO,  FILL_HALVES,  1'b0, MARK_OPPOSE},  // end marks on words that do not count
    '{SET_ONES,  FILL_CHECKER, 1'b1, MARK_AGREE},   // settings change between blocks of one message
    '{SET_MIXED, FILL_COUNT,   1'b1, MARK_RANDOM}
  };

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       start      = 1'b0;
  logic       busy;
  word_t      msg_word   = '0;
  logic       last_block = 1'b0;
  logic       cfg_we     = 1'b0;
  logic [2:0] cfg_index  = REG_KEY_01;
  logic [63:0] cfg_data  = '0;
  logic       done;
  word_t      digest_word;
  logic [2:0] word_index;
  logic       last_out;

  // predictor state
  logic [63:0]  reg_copy [8];
  word_t        chain [8];
  word_t        msg_buf [16];
  word_t        mix_v [16];
  logic [3:0]   fill_count = '0;
  logic         new_message = 1'b1;
  digest_beat_t digest_q [$];
  digest_beat_t want;

  int send_idle_pct = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  blake3_chained_block_compress dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .msg_word    (msg_word),
    .last_block  (last_block),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_out    (last_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic word_t rotr(word_t w, int n);
    return (w >> n) | (w << (32 - n));
  endfunction

  function automatic void g_mix(int a, int b, int c, int d, word_t x, word_t y);
    mix_v[a] = mix_v[a] + mix_v[b] + x;
    mix_v[d] = rotr(mix_v[d] ^ mix_v[a], 16);
    mix_v[c] = mix_v[c] + mix_v[d];
    mix_v[b] = rotr(mix_v[b] ^ mix_v[c], 12);
    mix_v[a] = mix_v[a] + mix_v[b] + y;
    mix_v[d] = rotr(mix_v[d] ^ mix_v[a], 8);
    mix_v[c] = mix_v[c] + mix_v[d];
    mix_v[b] = rotr(mix_v[b] ^ mix_v[c], 7);
  endfunction

  function automatic void compress_block(logic [7:0] flags);
    word_t m [16];
    word_t p [16];
    logic [63:0] ctr;
    ctr = reg_copy[REG_COUNTER];
    for (int i = 0; i < 16; i++) m[i] = msg_buf[i];
    for (int i = 0; i < 8; i++) mix_v[i] = chain[i];
    for (int i = 0; i < 4; i++) mix_v[8 + i] = CHAIN_IV[i];
    mix_v[12] = ctr[31:0];
    mix_v[13] = ctr[63:32];
    mix_v[14] = 32'd64;
    mix_v[15] = {24'd0, flags};
    for (int r = 0; r < 7; r++) begin
      g_mix(0, 4, 8, 12, m[0], m[1]);
      g_mix(1, 5, 9, 13, m[2], m[3]);
      g_mix(2, 6, 10, 14, m[4], m[5]);
      g_mix(3, 7, 11, 15, m[6], m[7]);
      g_mix(0, 5, 10, 15, m[8], m[9]);
      g_mix(1, 6, 11, 12, m[10], m[11]);
      g_mix(2, 7, 8, 13, m[12], m[13]);
      g_mix(3, 4, 9, 14, m[14], m[15]);
      for (int i = 0; i < 16; i++) p[i] = m[SCHEDULE[i]];
      for (int i = 0; i < 16; i++) m[i] = p[i];
    end
    for (int i = 0; i < 8; i++) chain[i] = mix_v[i] ^ mix_v[i + 8];
  endfunction

  // takes one accepted word; on the end of a last block queues the eight digest words
  function automatic void absorb_word(word_t w, logic lst);
    logic [7:0]   flags;
    logic [63:0]  k;
    digest_beat_t beat;
    msg_buf[fill_count] = w;
    fill_count = fill_count + 4'd1;
    if (fill_count == 4'd0) begin
      flags = reg_copy[REG_BASE_FLAGS][7:0];
      if (new_message) begin
        for (int i = 0; i < 4; i++) begin
          k = reg_copy[int'(REG_KEY_01) + i];
          chain[2 * i] = k[31:0];
          chain[2 * i + 1] = k[63:32];
        end
        flags = flags | reg_copy[REG_START_FLAGS][7:0];
        new_message = 1'b0;
      end
      if (lst) flags = flags | reg_copy[REG_END_FLAGS][7:0];
      compress_block(flags);
      if (lst) begin
        for (int i = 0; i < 8; i++) begin
          beat.word = chain[i];
          beat.index = 3'(i);
          beat.last = (i == 7);
          digest_q.push_back(beat);
        end
        new_message = 1'b1;
      end
    end
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] exp_val, logic [31:0] got_val);
    $display("%0t: %s expected %h, got %h", $time, what, exp_val, got_val);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (digest_q.size() == 0) begin
        flag_mismatch("digest transfer with none pending, word", 32'd0, digest_word);
      end else begin
        want = digest_q.pop_front();
        if (digest_word !== want.word) flag_mismatch("digest_word", want.word, digest_word);
        if (word_index !== want.index)
          flag_mismatch("word_index", 32'(want.index), 32'(word_index));
        if (last_out !== want.last)
          flag_mismatch("last_out", 32'(want.last), 32'(last_out));
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if ((start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_blake3_chained_block_compress: FAIL");
      $finish;
    end
  end

  task automatic send_word(word_t w, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    msg_word <= w;
    last_block <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_word(w, lst);
  endtask

  task automatic send_block(fill_t fill, logic lst, mark_t marks);
    word_t w;
    logic  mark;
    for (int i = 0; i < 16; i++) begin
      case (fill)
        FILL_ZERO:    w = '0;
        FILL_ONES:    w = '1;
        FILL_HALVES:  w = i[0] ? 32'hFFFF0000 : 32'h0000FFFF;
        FILL_CHECKER: w = i[0] ? 32'h55555555 : 32'hAAAAAAAA;
        FILL_COUNT:   w = 32'(i);
        default:      w = $urandom;
      endcase
      if (i == 15) mark = lst;
      else begin
        case (marks)
          MARK_AGREE:  mark = lst;
          MARK_OPPOSE: mark = !lst;
          default:     mark = 1'($urandom_range(1));
        endcase
      end
      send_word(w, mark);
    end
  endtask

  task automatic send_message(int blocks);
    fill_t fill;
    for (int b = 0; b < blocks; b++) begin
      fill = ($urandom_range(7) == 0) ? fill_t'($urandom_range(int'(FILL_COUNT))) : FILL_RANDOM;
      send_block(fill, b == blocks - 1, MARK_RANDOM);
    end
  endtask

  // holds the sender off until every digest word is out and the core has gone quiet
  task automatic wait_for_digests();
    start <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(setting_t mode);
    reg_index_t  ri;
    logic [63:0] val;
    ri = REG_KEY_01;
    repeat (8) begin
      case (mode)
        SET_ZERO:   val = '0;
        SET_ONES:   val = '1;
        SET_RANDOM: val = {$urandom, $urandom};
        default: begin
          case ($urandom_range(2))
            0:       val = '0;
            1:       val = '1;
            default: val = {$urandom, $urandom};
          endcase
        end
      endcase
      cfg_we <= 1'b1;
      cfg_index <= ri;
      cfg_data <= val;
      @(posedge clk);
      reg_copy[ri] = val;
      ri = ri.next();
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int sent;
    int blocks;
    for (int i = 0; i < 8; i++) reg_copy[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 5; i++) begin
      if (DIRECTED[i].settings != SET_KEEP) begin
        wait_for_digests();
        apply_settings(DIRECTED[i].settings);
      end
      send_block(DIRECTED[i].fill, DIRECTED[i].last, DIRECTED[i].marks);
    end

    for (int ph = 0; ph < 3; ph++) begin
      wait_for_digests();
      apply_settings(ph == 0 ? SET_RANDOM : SET_MIXED);
      send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 52 : 0;
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        case ($urandom_range(9))
          0, 1: begin
            wait_for_digests();
            apply_settings(setting_t'($urandom_range(int'(SET_MIXED), int'(SET_ZERO))));
          end
          2: wait_for_digests();
          default: ;
        endcase
        blocks = ($urandom_range(3) == 0) ? 3 : $urandom_range(2, 1);
        send_message(blocks);
        sent += 16 * blocks;
      end
    end

    wait_for_digests();
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("tb_blake3_chained_block_compress: PASS");
    end else begin
      $display("tb_blake3_chained_block_compress: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/b3c_pkg.sv
sv/b3c_front.sv
sv/b3c_queue.sv
sv/b3c_core.sv
sv/blake3_chained_block_compress.sv
tb/tb_blake3_chained_block_compress.sv
